@@ rtl/wrrq_pkg.sv @@
// Package for the weighted round-robin run queue.
// Holds field widths, function codes and the request/response beat types.
// No dependencies.
package wrrq_pkg;

  // Field widths
  localparam int TASK_W  = 6;
  localparam int WGT_W   = 5;
  localparam int SLICE_W = 13;
  localparam int CNT_W   = 7;
  localparam int TOT_W   = 11;
  localparam int UNIT_W  = 8;
  localparam int FUNC_W  = 3;

  // Defaults
  localparam int                MAX_TASKS_DEF  = 64;
  localparam logic [UNIT_W-1:0] SLICE_UNIT_RST = 8'd10;

  // Function codes
  localparam logic [FUNC_W-1:0] FN_ENQ   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_YIELD = 3'd2;
  localparam logic [FUNC_W-1:0] FN_PICK  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_TICK  = 3'd4;

  // Request beat
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [TASK_W-1:0] task_id;
    logic [WGT_W-1:0]  weight;
    logic [TASK_W-1:0] prev_task;
    logic              prev_valid;
    logic              current_is_member;
  } req_t;

  // Response beat
  typedef struct packed {
    logic [TASK_W-1:0] next_task;
    logic              next_valid;
    logic              resched;
    logic [CNT_W-1:0]  queue_count;
    logic [TOT_W-1:0]  weight_total;
  } rsp_t;

endpackage

@@ rtl/weighted_round_robin_run_queue.sv @@
// Weighted round-robin run queue, top level.
// Depends on wrrq_pkg.
//
// Usage:
//   req channel (req_valid / req_stall / req) carries one command beat:
//   enqueue, dequeue, yield, pick next or tick. rsp channel (rsp_valid /
//   rsp_stall / rsp) returns exactly one beat per command with the picked
//   task, the reschedule flag, the queue count and the total weight.
//   cfg_wr_en / cfg_wr_data write the slice unit; write it only while idle.
// Sequencing:
//   A command is taken in idle, updated in the execute state, then issues its
//   link-memory writes (0 to 4) one at a time through the single link write port.
//   The response register loads as the last execute or write state ends.
// Reset:
//   Synchronous, active high; req_stall is held high. Clears the queue, head,
//   tail, count and total and sets the slice unit to 10. Link and task
//   memories are not cleared; no clearing pass is needed.
// Stall:
//   A finished beat waits in the output register while rsp_stall is high;
//   the next command is still taken and its result held until it frees.
module weighted_round_robin_run_queue #(
  parameter int MAX_TASKS = wrrq_pkg::MAX_TASKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  wrrq_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output wrrq_pkg::rsp_t                rsp,
  input  logic                          cfg_wr_en,
  input  logic [wrrq_pkg::UNIT_W-1:0]   cfg_wr_data
);
  import wrrq_pkg::*;

  // Ids above 63 cannot occur, so storage stops there
  localparam int DEPTH  = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
  localparam int ADDR_W = $clog2(DEPTH);

  // Pending link write slots, issued in this order
  localparam int PW_CN   = 0;  // next of predecessor
  localparam int PW_CP   = 1;  // prev of successor
  localparam int PW_TN   = 2;  // next of old tail
  localparam int PW_SELF = 3;  // both links of the moved or appended task
  localparam int PW_N    = 4;

  typedef struct packed {
    logic [TASK_W-1:0] nxt;
    logic [TASK_W-1:0] prv;
  } link_t;

  typedef struct packed {
    logic [WGT_W-1:0]   wgt;
    logic [SLICE_W-1:0] slc;
  } tdat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WRITE,
    ST_OUT
  } state_t;

  state_t state;

  // Control and queue state
  logic [UNIT_W-1:0]  slice_unit;
  logic [DEPTH-1:0]   queued;
  logic [TASK_W-1:0]  head;
  logic [TASK_W-1:0]  tail;
  logic [CNT_W-1:0]   cnt;
  logic [TOT_W-1:0]   tot;
  req_t               cur;
  rsp_t               res;
  logic [PW_N-1:0]    pend;
  logic [TASK_W-1:0]  wr_p;
  logic [TASK_W-1:0]  wr_n;
  logic [TASK_W-1:0]  wr_tail;
  logic [TASK_W-1:0]  wr_t;
  logic [TASK_W-1:0]  wr_sprev;

  // Memories
  link_t link_mem [DEPTH];
  tdat_t tdat_mem [DEPTH];
  link_t lk_rd;
  tdat_t dat_rd;

  logic               accept;
  logic [TASK_W-1:0]  rd_id;
  logic               out_free;

  assign req_stall = rst || (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rd_id     = (req.func == FN_PICK) ? req.prev_task : req.task_id;
  assign out_free  = !rsp_valid || !rsp_stall;

  // Command decode and queue update, evaluated in the execute cycle
  logic [TASK_W-1:0]  t_id;
  logic [ADDR_W-1:0]  t_ix;
  logic               ok;
  logic               q;
  logic               is_head;
  logic               is_tail;
  logic               move;
  logic [WGT_W-1:0]   mul_w;
  logic [SLICE_W-1:0] load;
  logic [SLICE_W-1:0] dec;
  logic [TASK_W-1:0]  head_next;
  logic [TASK_W-1:0]  tail_next;
  logic [CNT_W-1:0]   cnt_next;
  logic [TOT_W-1:0]   tot_next;
  logic [PW_N-1:0]    pend_next;
  logic [TASK_W-1:0]  wr_sprev_next;
  logic               q_set;
  logic               q_clr;
  logic               dat_we;
  tdat_t              dat_wd;
  rsp_t               res_next;

  always_comb begin
    t_id          = (cur.func == FN_PICK) ? cur.prev_task : cur.task_id;
    t_ix          = t_id[ADDR_W-1:0];
    ok            = int'(t_id) < MAX_TASKS;
    q             = queued[t_ix];
    is_head       = (t_id == head);
    is_tail       = (t_id == tail);
    mul_w         = (cur.func == FN_ENQ) ? cur.weight : dat_rd.wgt;
    load          = SLICE_W'(mul_w) * SLICE_W'(slice_unit);
    dec           = dat_rd.slc - SLICE_W'(1);
    move          = 1'b0;
    head_next     = head;
    tail_next     = tail;
    cnt_next      = cnt;
    tot_next      = tot;
    pend_next     = '0;
    wr_sprev_next = tail;
    q_set         = 1'b0;
    q_clr         = 1'b0;
    dat_we        = 1'b0;
    dat_wd        = dat_rd;
    res_next      = '0;

    case (cur.func)
      FN_ENQ: begin
        if (ok && !q) begin
          pend_next[PW_SELF] = 1'b1;
          if (cnt != '0) begin
            pend_next[PW_TN] = 1'b1;
          end else begin
            head_next     = t_id;
            wr_sprev_next = t_id;
          end
          tail_next = t_id;
          q_set     = 1'b1;
          dat_we    = 1'b1;
          dat_wd    = '{wgt: cur.weight, slc: load};
          cnt_next  = cnt + CNT_W'(1);
          tot_next  = tot + TOT_W'(cur.weight);
        end
      end
      FN_DEQ: begin
        if (ok && q) begin
          if (is_head) head_next = lk_rd.nxt;
          else         pend_next[PW_CN] = 1'b1;
          if (is_tail) tail_next = lk_rd.prv;
          else         pend_next[PW_CP] = 1'b1;
          q_clr    = 1'b1;
          cnt_next = cnt - CNT_W'(1);
          tot_next = tot - TOT_W'(dat_rd.wgt);
        end
      end
      FN_YIELD: begin
        move = ok && q && !is_tail;
      end
      FN_PICK: begin
        move = cur.prev_valid && ok && q && !is_tail;
      end
      FN_TICK: begin
        if (ok && cur.current_is_member) begin
          dat_we = 1'b1;
          if (dec == '0) begin
            dat_wd.slc = load;
            if (q && cnt >= CNT_W'(2)) begin
              res_next.resched = 1'b1;
              move             = !is_tail;
            end
          end else begin
            dat_wd.slc = dec;
          end
        end
      end
      default: begin
      end
    endcase

    // Move the task to the tail: unlink, then append
    if (move) begin
      if (is_head) head_next = lk_rd.nxt;
      else         pend_next[PW_CN] = 1'b1;
      pend_next[PW_CP]   = 1'b1;
      pend_next[PW_TN]   = 1'b1;
      pend_next[PW_SELF] = 1'b1;
      wr_sprev_next      = tail;
      tail_next          = t_id;
    end

    // Pick reports the head after any requeue
    if (cur.func == FN_PICK && cnt != '0) begin
      res_next.next_task  = head_next;
      res_next.next_valid = 1'b1;
    end
    res_next.queue_count  = cnt_next;
    res_next.weight_total = tot_next;
  end

  // Link write port: one pending write per cycle
  logic              lk_we_n;
  logic              lk_we_p;
  logic [TASK_W-1:0] lk_wa;
  logic [TASK_W-1:0] lk_wn;
  logic [TASK_W-1:0] lk_wp;
  logic [PW_N-1:0]   pend_left;

  always_comb begin
    lk_we_n   = 1'b0;
    lk_we_p   = 1'b0;
    lk_wa     = wr_t;
    lk_wn     = wr_t;
    lk_wp     = wr_sprev;
    pend_left = pend;
    if (state == ST_WRITE) begin
      if (pend[PW_CN]) begin
        lk_we_n          = 1'b1;
        lk_wa            = wr_p;
        lk_wn            = wr_n;
        pend_left[PW_CN] = 1'b0;
      end else if (pend[PW_CP]) begin
        lk_we_p          = 1'b1;
        lk_wa            = wr_n;
        lk_wp            = wr_p;
        pend_left[PW_CP] = 1'b0;
      end else if (pend[PW_TN]) begin
        lk_we_n          = 1'b1;
        lk_wa            = wr_tail;
        lk_wn            = wr_t;
        pend_left[PW_TN] = 1'b0;
      end else if (pend[PW_SELF]) begin
        lk_we_n            = 1'b1;
        lk_we_p            = 1'b1;
        pend_left[PW_SELF] = 1'b0;
      end
    end
  end

  // Load the response register once the last write is done and it is free
  logic rsp_load;

  assign rsp_load = out_free && ((state == ST_EXEC && pend_next == '0) ||
                                 (state == ST_WRITE && pend_left == '0) ||
                                 (state == ST_OUT));

  // Link memory: field write enables, registered read on accept
  always_ff @(posedge clk) begin
    if (lk_we_n) link_mem[lk_wa[ADDR_W-1:0]].nxt <= lk_wn;
    if (lk_we_p) link_mem[lk_wa[ADDR_W-1:0]].prv <= lk_wp;
    if (accept)  lk_rd <= link_mem[rd_id[ADDR_W-1:0]];
  end

  // Task data memory: weight and slice, written in the execute cycle
  always_ff @(posedge clk) begin
    if (state == ST_EXEC && dat_we) tdat_mem[t_ix] <= dat_wd;
    if (accept)                     dat_rd <= tdat_mem[rd_id[ADDR_W-1:0]];
  end

  // Sequencer, queue registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      slice_unit <= SLICE_UNIT_RST;
      queued     <= '0;
      head       <= '0;
      tail       <= '0;
      cnt        <= '0;
      tot        <= '0;
      pend       <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_wr_en) slice_unit <= cfg_wr_data;
      // load a finished beat, else drop a taken one
      if (rsp_load)                     rsp_valid <= 1'b1;
      else if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            cur   <= req;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          head     <= head_next;
          tail     <= tail_next;
          cnt      <= cnt_next;
          tot      <= tot_next;
          if (q_set) queued[t_ix] <= 1'b1;
          if (q_clr) queued[t_ix] <= 1'b0;
          pend     <= pend_next;
          wr_p     <= lk_rd.prv;
          wr_n     <= lk_rd.nxt;
          wr_tail  <= tail;
          wr_t     <= t_id;
          wr_sprev <= wr_sprev_next;
          res      <= res_next;
          if (pend_next != '0) begin
            state <= ST_WRITE;
          end else if (out_free) begin
            rsp   <= res_next;
            state <= ST_IDLE;
          end else begin
            state <= ST_OUT;
          end
        end
        ST_WRITE: begin
          pend <= pend_left;
          if (pend_left == '0) begin
            if (out_free) begin
              rsp   <= res;
              state <= ST_IDLE;
            end else begin
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_free) begin
            rsp   <= res;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ tb/sv/weighted_round_robin_run_queue_tb.sv @@
// Testbench for the weighted round-robin run queue: directed table, then random phases.
// Checks every response beat against an in-bench run queue model, or a typed table row's expected beat.
// Depends on wrrq_pkg and weighted_round_robin_run_queue.
`timescale 1ns / 100ps

module weighted_round_robin_run_queue_tb;
  import wrrq_pkg::*;

  localparam int                N_TASKS       = MAX_TASKS_DEF;
  localparam int                N_PHASES      = 6;
  localparam int                PHASE_BEATS   = 205;
  localparam int                CALM_PHASE    = 2;
  localparam int                SETTLE_CYCLES = 12;
  localparam int                CYCLE_LIMIT   = 400_000;
  localparam logic [FUNC_W-1:0] FN_SPARE_LO   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_HI   = 3'd7;
  localparam rsp_t              QUIET_RSP     = '0;

  typedef struct {
    req_t cmd;
    int   reps;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic              clk;
  logic              rst         = 1'b1;
  logic              req_valid   = 1'b0;
  logic              req_stall;
  req_t              req         = '0;
  logic              rsp_valid;
  logic              rsp_stall   = 1'b0;
  rsp_t              rsp;
  logic              cfg_wr_en   = 1'b0;
  logic [UNIT_W-1:0] cfg_wr_data = '0;

  // Run queue model state
  bit                 on_queue    [N_TASKS];
  bit                 slice_valid [N_TASKS];
  logic [TASK_W-1:0]  link_next   [N_TASKS];
  logic [TASK_W-1:0]  link_prev   [N_TASKS];
  logic [WGT_W-1:0]   task_wgt    [N_TASKS];
  logic [SLICE_W-1:0] slice_cnt   [N_TASKS];
  logic [TASK_W-1:0]  q_head      = '0;
  logic [TASK_W-1:0]  q_tail      = '0;
  logic [CNT_W-1:0]   q_count     = '0;
  logic [TOT_W-1:0]   q_wsum      = '0;
  logic [UNIT_W-1:0]  unit_now    = SLICE_UNIT_RST;
  int                 known_cnt   = 0;

  rsp_t pending_rsp[$];
  int   fail_cnt  = 0;
  int   cycle_cnt = 0;
  bit   calm      = 1'b0;

  weighted_round_robin_run_queue DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 25);
  endfunction

  // Unlink a task from the order; count untouched
  function automatic void unlink_task(logic [TASK_W-1:0] t);
    logic [TASK_W-1:0] p, n;
    p = link_prev[t];
    n = link_next[t];
    if (t == q_head) q_head = n;
    else link_next[p] = n;
    if (t == q_tail) q_tail = p;
    else link_prev[n] = p;
  endfunction

  function automatic void append_task(logic [TASK_W-1:0] t, bit others);
    if (!others) begin
      q_head = t;
      link_prev[t] = t;
    end else begin
      link_next[q_tail] = t;
      link_prev[t] = q_tail;
    end
    link_next[t] = t;
    q_tail = t;
  endfunction

  function automatic void send_to_tail(logic [TASK_W-1:0] t);
    if (!on_queue[t] || t == q_tail) return;
    unlink_task(t);
    append_task(t, 1'b1);
  endfunction

  function automatic logic [SLICE_W-1:0] slice_reload(logic [TASK_W-1:0] t);
    return SLICE_W'(int'(task_wgt[t]) * int'(unit_now));
  endfunction

  // Advance the model by one command and return the response it owes
  function automatic rsp_t apply_command(req_t c);
    rsp_t              r;
    logic [TASK_W-1:0] t;
    r = '0;
    t = c.task_id;
    case (c.func)
      FN_ENQ: begin
        if (!on_queue[t]) begin
          append_task(t, q_count != 0);
          on_queue[t] = 1'b1;
          task_wgt[t] = c.weight;
          slice_cnt[t] = slice_reload(t);
          if (!slice_valid[t]) begin
            slice_valid[t] = 1'b1;
            known_cnt++;
          end
          q_count = q_count + 7'd1;
          q_wsum = q_wsum + TOT_W'(c.weight);
        end
      end
      FN_DEQ: begin
        if (on_queue[t]) begin
          unlink_task(t);
          on_queue[t] = 1'b0;
          q_count = q_count - 7'd1;
          q_wsum = q_wsum - TOT_W'(task_wgt[t]);
        end
      end
      FN_YIELD: send_to_tail(t);
      FN_PICK: begin
        if (c.prev_valid) send_to_tail(c.prev_task);
        if (q_count != 0) begin
          r.next_task = q_head;
          r.next_valid = 1'b1;
        end
      end
      FN_TICK: begin
        if (c.current_is_member) begin
          slice_cnt[t] = slice_cnt[t] - 1'b1;
          if (slice_cnt[t] == 0) begin
            slice_cnt[t] = slice_reload(t);
            if (on_queue[t] && q_count >= 2) begin
              send_to_tail(t);
              r.resched = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.queue_count = q_count;
    r.weight_total = q_wsum;
    return r;
  endfunction

  function automatic logic [TASK_W-1:0] nth_queued(int k);
    logic [TASK_W-1:0] t;
    t = q_head;
    repeat (k) t = link_next[t];
    return t;
  endfunction

  // Draw a random command; odd phases fill the queue, even phases drain it
  function automatic req_t next_command(int ph);
    req_t c;
    int   roll, enq_pct, deq_pct, tries;
    c.func = FN_TICK;
    c.task_id = TASK_W'($urandom_range(0, N_TASKS - 1));
    c.weight = WGT_W'($urandom_range(0, 31));
    c.prev_task = TASK_W'($urandom_range(0, N_TASKS - 1));
    c.prev_valid = 1'($urandom_range(0, 1));
    c.current_is_member = 1'($urandom_range(0, 1));
    enq_pct = (ph % 2) ? 35 : 12;
    deq_pct = (ph % 2) ? 6 : 22;
    roll = $urandom_range(0, 99);
    if (roll < enq_pct) begin
      c.func = FN_ENQ;
      tries = 0;
      while (on_queue[c.task_id] && tries < 4) begin
        c.task_id = TASK_W'($urandom_range(0, N_TASKS - 1));
        tries++;
      end
      if ($urandom_range(0, 9) < 7) c.weight = WGT_W'($urandom_range(1, 4));
    end else if (roll < enq_pct + deq_pct) begin
      c.func = FN_DEQ;
      if (q_count != 0 && $urandom_range(0, 9) < 8)
        c.task_id = nth_queued($urandom_range(0, int'(q_count) - 1));
    end else if (roll < enq_pct + deq_pct + 10) begin
      c.func = FN_YIELD;
      if (q_count != 0 && $urandom_range(0, 9) < 8)
        c.task_id = nth_queued($urandom_range(0, int'(q_count) - 1));
    end else if (roll < enq_pct + deq_pct + 28) begin
      c.func = FN_PICK;
      c.prev_valid = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 1)) c.prev_task = q_head;
    end else if (roll < enq_pct + deq_pct + 32) begin
      c.func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
    end else begin
      // Tick mostly the running head; only tasks with a loaded slice
      c.current_is_member = ($urandom_range(0, 9) != 0);
      if (known_cnt == 0) c.current_is_member = 1'b0;
      else if (q_count != 0 && $urandom_range(0, 9) < 7) c.task_id = q_head;
      else
        while (!slice_valid[c.task_id]) c.task_id = TASK_W'($urandom_range(0, N_TASKS - 1));
    end
    return c;
  endfunction

  function automatic plan_row_t mk_row(logic [FUNC_W-1:0] f, int t, int w, int pt, bit pv,
                                       bit m, int reps, bit typed, rsp_t want);
    plan_row_t row;
    row.cmd.func = f;
    row.cmd.task_id = TASK_W'(t);
    row.cmd.weight = WGT_W'(w);
    row.cmd.prev_task = TASK_W'(pt);
    row.cmd.prev_valid = pv;
    row.cmd.current_is_member = m;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic rsp_t stat_rsp(int cnt, int tot);
    rsp_t r;
    r = '0;
    r.queue_count = CNT_W'(cnt);
    r.weight_total = TOT_W'(tot);
    return r;
  endfunction

  // Present one beat, hold it through stall, predict on acceptance
  task automatic send_beat(input req_t cmd, input bit typed, input rsp_t want);
    rsp_t guess;
    if (take_break()) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while (take_break()) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= cmd;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    guess = apply_command(cmd);
    pending_rsp.push_back(typed ? want : guess);
  endtask

  // Wait out every owed response, then let the block go quiet
  task automatic settle();
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_slice_unit(input logic [UNIT_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unit_now = v;
  endtask

  // Receive side: random stall, check each accepted beat
  always @(posedge clk) begin
    rsp_t w;
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= take_break();
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        $error("response beat with none outstanding");
        fail_cnt++;
      end else begin
        w = pending_rsp.pop_front();
        if (rsp.next_task !== w.next_task) begin
          $error("next_task: expected %0d, got %0d", w.next_task, rsp.next_task);
          fail_cnt++;
        end
        if (rsp.next_valid !== w.next_valid) begin
          $error("next_valid: expected %0d, got %0d", w.next_valid, rsp.next_valid);
          fail_cnt++;
        end
        if (rsp.resched !== w.resched) begin
          $error("resched: expected %0d, got %0d", w.resched, rsp.resched);
          fail_cnt++;
        end
        if (rsp.queue_count !== w.queue_count) begin
          $error("queue_count: expected %0d, got %0d", w.queue_count, rsp.queue_count);
          fail_cnt++;
        end
        if (rsp.weight_total !== w.weight_total) begin
          $error("weight_total: expected %0d, got %0d", w.weight_total, rsp.weight_total);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    plan_row_t                plan[$];
    logic [UNIT_W-1:0]        units[N_PHASES];
    int                       ph;
    int                       k;

    units = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd1, 8'd5};
    for (k = 0; k < N_TASKS; k++) begin
      on_queue[k] = 1'b0;
      slice_valid[k] = 1'b0;
    end

    // Empty queue, ignored commands, spare codes
    plan.push_back(mk_row(FN_PICK, 0, 0, 0, 1, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_TICK, 5, 0, 0, 0, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_DEQ, 7, 0, 0, 0, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_YIELD, 7, 0, 0, 0, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_SPARE_LO, 0, 0, 0, 0, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_SPARE_HI, 63, 31, 63, 1, 1, 1, 1, QUIET_RSP));
    // Fill with extreme ids and weights, repeat enqueue is dropped
    plan.push_back(mk_row(FN_ENQ, 0, 31, 0, 0, 0, 1, 1, stat_rsp(1, 31)));
    plan.push_back(mk_row(FN_ENQ, 63, 0, 0, 0, 0, 1, 1, stat_rsp(2, 31)));
    plan.push_back(mk_row(FN_ENQ, 0, 5, 0, 0, 0, 1, 1, stat_rsp(2, 31)));
    plan.push_back(mk_row(FN_ENQ, 32, 1, 0, 0, 0, 1, 1, stat_rsp(3, 32)));
    // Pick with and without requeue, yield, slice wrap, slice expiry
    plan.push_back(mk_row(FN_PICK, 0, 0, 0, 0, 0, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_PICK, 0, 0, 0, 1, 0, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_PICK, 0, 0, 5, 1, 0, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_YIELD, 63, 0, 0, 0, 0, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_YIELD, 63, 0, 0, 0, 0, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_TICK, 63, 0, 0, 0, 1, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_TICK, 32, 0, 0, 0, 1, 9, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_TICK, 32, 0, 0, 0, 1, 1, 0, QUIET_RSP));
    plan.push_back(mk_row(FN_PICK, 0, 0, 0, 0, 0, 1, 0, QUIET_RSP));
    // Drain down; expiry alone in the queue and while unqueued
    plan.push_back(mk_row(FN_DEQ, 0, 0, 0, 0, 0, 1, 1, stat_rsp(2, 1)));
    plan.push_back(mk_row(FN_DEQ, 32, 0, 0, 0, 0, 1, 1, stat_rsp(1, 0)));
    plan.push_back(mk_row(FN_ENQ, 32, 1, 0, 0, 0, 1, 1, stat_rsp(2, 1)));
    plan.push_back(mk_row(FN_DEQ, 63, 0, 0, 0, 0, 1, 1, stat_rsp(1, 1)));
    plan.push_back(mk_row(FN_TICK, 32, 0, 0, 0, 1, 10, 1, stat_rsp(1, 1)));
    plan.push_back(mk_row(FN_DEQ, 32, 0, 0, 0, 0, 1, 1, QUIET_RSP));
    plan.push_back(mk_row(FN_TICK, 32, 0, 0, 0, 1, 10, 1, QUIET_RSP));

    // Hold reset
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table at the reset slice unit
    foreach (plan[i]) begin
      repeat (plan[i].reps) send_beat(plan[i].cmd, plan[i].typed, plan[i].want);
    end
    req_valid <= 1'b0;
    settle();

    // Random phases, one slice unit each, one phase with no idling
    for (ph = 0; ph < N_PHASES; ph++) begin
      set_slice_unit(units[ph]);
      calm = (ph == CALM_PHASE);
      repeat (PHASE_BEATS) send_beat(next_command(ph), 1'b0, QUIET_RSP);
      req_valid <= 1'b0;
      calm = 1'b0;
      settle();
    end

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
